// ===== hdl/assert_macros.svh =====
// Concurrent assertion macros used by the base relocation walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_sig, rst_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPLY(lbl, clk_sig, rst_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/brw_pkg.sv =====
// Types and constants for the base relocation walker.
package brw_pkg;

    localparam logic [31:0] HEADER_BYTES = 32'd8;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_SIZE = 2'd0;
    localparam logic [1:0] CFG_DIR_BYTES  = 2'd1;
    localparam logic [1:0] CFG_BASE_DELTA = 2'd2;

    // Input item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_HALF  = 1'b1;

    // Walk status codes
    localparam logic [1:0] ST_WALKING  = 2'd0;
    localparam logic [1:0] ST_FINISHED = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;

    // Patch width codes
    localparam logic [1:0] PW_16 = 2'd0;
    localparam logic [1:0] PW_32 = 2'd1;
    localparam logic [1:0] PW_64 = 2'd2;

    // Relocation entry types
    localparam logic [3:0] RT_ABSOLUTE = 4'd0;
    localparam logic [3:0] RT_HIGH     = 4'd1;
    localparam logic [3:0] RT_LOW      = 4'd2;
    localparam logic [3:0] RT_HIGHLOW  = 4'd3;
    localparam logic [3:0] RT_DIR64    = 4'd10;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_WALK = 4'b0010,
        PH_DONE = 4'b0100,
        PH_ERR  = 4'b1000
    } phase_t;

endpackage

// ===== hdl/base_relocation_walker.sv =====
// Base relocation walker: directory halfword stream in, patch commands out.
// One item (a start or one directory halfword) is taken per clock cycle unless the
// input side stalls; each item is registered, decoded against the walk state and its
// result, if any, lands in an output register. The input side stalls only when the
// input register is full and the output register holds a result that is not being
// taken. Configuration registers are written through cfg_write/cfg_index/cfg_data;
// the user must write them only while idle; the block itself does not enforce it.
`include "assert_macros.svh"

module base_relocation_walker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        kind,
    input  logic [15:0] directory_half,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        patch_valid,
    output logic [31:0] target_offset,
    output logic [1:0]  patch_width,
    output logic [63:0] addend,
    output logic [1:0]  walk_status
);

    // configuration
    logic [31:0] image_size_reg;
    logic [31:0] dir_bytes_reg;
    logic [63:0] base_delta_reg;

    // input register
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_kind_reg;
    logic [15:0] s1_half_reg;

    // walk state
    brw_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  header_step_reg, header_step_next;
    logic [31:0] page_rva_reg, page_rva_next;
    logic [31:0] block_bytes_reg, block_bytes_next;
    logic [30:0] entries_left_reg, entries_left_next;
    logic [31:0] bytes_done_reg, bytes_done_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        out_patch_reg;
    logic [31:0] out_target_reg;
    logic [1:0]  out_width_reg;
    logic [63:0] out_addend_reg;
    logic [1:0]  out_status_reg;

    logic        out_free;
    logic        advance;

    // decode results
    logic        res_fire;
    logic        res_patch;
    logic [31:0] res_target;
    logic [1:0]  res_width;
    logic [63:0] res_addend;
    logic [1:0]  res_status;

    logic [31:0] hdr_bytes;
    logic [31:0] remaining;
    logic [31:0] blk_add;
    logic [31:0] done_sum;
    logic        blk_finish;
    logic        blk_short;
    logic [32:0] target_sum;
    logic [33:0] end_sum;
    logic [3:0]  ent_type;
    logic [3:0]  ent_nbytes;
    logic        ent_patch;
    logic [1:0]  ent_width;
    logic [63:0] ent_addend;
    logic        out_image;
    logic [1:0]  blk_status;

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = s1_valid_reg && out_free;
    assign item_stall = s1_valid_reg && !out_free;

    always_comb
    begin
        if (item_valid && !item_stall)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // shared datapath
    assign hdr_bytes  = {s1_half_reg, block_bytes_reg[15:0]};
    assign remaining  = dir_bytes_reg - bytes_done_reg;
    assign blk_add    = (entries_left_reg == 31'd0) ? brw_pkg::HEADER_BYTES : block_bytes_reg;
    assign done_sum   = bytes_done_reg + blk_add;
    assign blk_finish = done_sum >= dir_bytes_reg;
    assign blk_short  = (dir_bytes_reg - done_sum) < brw_pkg::HEADER_BYTES;
    assign blk_status = blk_finish ? brw_pkg::ST_FINISHED :
                        (blk_short ? brw_pkg::ST_ERROR : brw_pkg::ST_WALKING);

    assign ent_type   = s1_half_reg[15:12];
    assign target_sum = {1'b0, page_rva_reg} + {21'd0, s1_half_reg[11:0]};
    assign end_sum    = {1'b0, target_sum} + {30'd0, ent_nbytes};
    // target + size past the image end also covers a target at or past the end
    assign out_image  = end_sum > {2'b00, image_size_reg};

    always_comb
    begin
        ent_patch  = 1'b1;
        ent_nbytes = 4'd0;
        ent_width  = brw_pkg::PW_16;
        ent_addend = base_delta_reg;
        unique case (ent_type)
            brw_pkg::RT_HIGH:
            begin
                ent_nbytes = 4'd2;
                ent_addend = {16'd0, base_delta_reg[63:16]};
            end
            brw_pkg::RT_LOW:
            begin
                ent_nbytes = 4'd2;
            end
            brw_pkg::RT_HIGHLOW:
            begin
                ent_nbytes = 4'd4;
                ent_width  = brw_pkg::PW_32;
            end
            brw_pkg::RT_DIR64:
            begin
                ent_nbytes = 4'd8;
                ent_width  = brw_pkg::PW_64;
            end
            default:
            begin
                ent_patch = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        header_step_next  = header_step_reg;
        page_rva_next     = page_rva_reg;
        block_bytes_next  = block_bytes_reg;
        entries_left_next = entries_left_reg;
        bytes_done_next   = bytes_done_reg;
        res_fire          = 1'b0;
        res_patch         = 1'b0;
        res_target        = 32'd0;
        res_width         = brw_pkg::PW_16;
        res_addend        = 64'd0;
        res_status        = brw_pkg::ST_WALKING;

        if (s1_kind_reg == brw_pkg::KIND_START)
        begin
            header_step_next  = 2'd0;
            page_rva_next     = 32'd0;
            block_bytes_next  = 32'd0;
            entries_left_next = 31'd0;
            bytes_done_next   = 32'd0;
            if (base_delta_reg == 64'd0 || dir_bytes_reg == 32'd0)
            begin
                phase_next = brw_pkg::PH_DONE;
                res_fire   = 1'b1;
                res_status = brw_pkg::ST_FINISHED;
            end
            else if (dir_bytes_reg < brw_pkg::HEADER_BYTES)
            begin
                phase_next = brw_pkg::PH_ERR;
                res_fire   = 1'b1;
                res_status = brw_pkg::ST_ERROR;
            end
            else
            begin
                phase_next = brw_pkg::PH_WALK;
            end
        end
        else if (phase_reg == brw_pkg::PH_WALK)
        begin
            if (entries_left_reg == 31'd0)
            begin
                // block header, four halfwords
                header_step_next = header_step_reg + 2'd1;
                unique case (header_step_reg)
                    2'd0: page_rva_next = {16'd0, s1_half_reg};
                    2'd1: page_rva_next = {s1_half_reg, page_rva_reg[15:0]};
                    2'd2: block_bytes_next = {16'd0, s1_half_reg};
                    default: block_bytes_next = hdr_bytes;
                endcase
                if (header_step_reg == 2'd3)
                begin
                    if (hdr_bytes == 32'd0)
                    begin
                        phase_next = brw_pkg::PH_DONE;
                        res_fire   = 1'b1;
                        res_status = brw_pkg::ST_FINISHED;
                    end
                    else if (hdr_bytes < brw_pkg::HEADER_BYTES || hdr_bytes > remaining ||
                             hdr_bytes[0])
                    begin
                        phase_next = brw_pkg::PH_ERR;
                        res_fire   = 1'b1;
                        res_status = brw_pkg::ST_ERROR;
                    end
                    else if (hdr_bytes == brw_pkg::HEADER_BYTES)
                    begin
                        // header-only block
                        bytes_done_next = done_sum;
                        if (blk_status != brw_pkg::ST_WALKING)
                        begin
                            res_fire   = 1'b1;
                            res_status = blk_status;
                            phase_next = blk_finish ? brw_pkg::PH_DONE : brw_pkg::PH_ERR;
                        end
                    end
                    else
                    begin
                        entries_left_next = hdr_bytes[31:1] - 31'd4;
                    end
                end
            end
            else if (ent_patch && out_image)
            begin
                phase_next = brw_pkg::PH_ERR;
                res_fire   = 1'b1;
                res_status = brw_pkg::ST_ERROR;
            end
            else
            begin
                entries_left_next = entries_left_reg - 31'd1;
                if (entries_left_reg == 31'd1)
                begin
                    bytes_done_next  = done_sum;
                    header_step_next = 2'd0;
                    res_status       = blk_status;
                    if (blk_status != brw_pkg::ST_WALKING)
                        phase_next = blk_finish ? brw_pkg::PH_DONE : brw_pkg::PH_ERR;
                end
                if (ent_patch)
                begin
                    res_fire   = 1'b1;
                    res_patch  = 1'b1;
                    res_target = target_sum[31:0];
                    res_width  = ent_width;
                    res_addend = ent_addend;
                end
                else if (res_status != brw_pkg::ST_WALKING)
                begin
                    res_fire = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        if (advance && res_fire)
            out_valid_next = 1'b1;
        else if (out_valid_reg && result_stall)
            out_valid_next = 1'b1;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg <= 32'd0;
            dir_bytes_reg  <= 32'd0;
            base_delta_reg <= 64'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                brw_pkg::CFG_IMAGE_SIZE: image_size_reg <= cfg_data[31:0];
                brw_pkg::CFG_DIR_BYTES:  dir_bytes_reg  <= cfg_data[31:0];
                brw_pkg::CFG_BASE_DELTA: base_delta_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= brw_pkg::PH_IDLE;
            header_step_reg  <= 2'd0;
            page_rva_reg     <= 32'd0;
            block_bytes_reg  <= 32'd0;
            entries_left_reg <= 31'd0;
            bytes_done_reg   <= 32'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg        <= phase_next;
                header_step_reg  <= header_step_next;
                page_rva_reg     <= page_rva_next;
                block_bytes_reg  <= block_bytes_next;
                entries_left_reg <= entries_left_next;
                bytes_done_reg   <= bytes_done_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            s1_kind_reg <= kind;
            s1_half_reg <= directory_half;
        end
        if (advance && res_fire)
        begin
            out_patch_reg  <= res_patch;
            out_target_reg <= res_target;
            out_width_reg  <= res_width;
            out_addend_reg <= res_addend;
            out_status_reg <= res_status;
        end
    end

    assign result_valid  = out_valid_reg;
    assign patch_valid   = out_patch_reg;
    assign target_offset = out_target_reg;
    assign patch_width   = out_width_reg;
    assign addend        = out_addend_reg;
    assign walk_status   = out_status_reg;

    `ASSERT_IMPLY(a_patch_width, clk, rst_n, out_valid_reg && out_patch_reg, out_width_reg <= brw_pkg::PW_64, "patch transaction with bad width")
    `ASSERT_IMPLY(a_entries_header_step, clk, rst_n, entries_left_reg != 31'd0, header_step_reg == 2'd0, "entry phase with header step in progress")
    `ASSERT_IMPLY(a_finished_phase, clk, rst_n, out_valid_reg && out_status_reg == brw_pkg::ST_FINISHED, phase_reg == brw_pkg::PH_DONE, "finished status pending but walk not done")
    `ASSERT_IMPLY(a_error_phase, clk, rst_n, out_valid_reg && out_status_reg == brw_pkg::ST_ERROR, phase_reg == brw_pkg::PH_ERR, "error status pending but walk not in error")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for base_relocation_walker: directed and random directory walks, self-checking.
module tb;

    typedef struct packed {
        logic        k;
        logic [15:0] h;
    } dir_item_t;

    typedef struct packed {
        logic        pv;
        logic [31:0] tgt;
        logic [1:0]  pw;
        logic [63:0] add;
        logic [1:0]  st;
    } walk_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = brw_pkg::CFG_IMAGE_SIZE;
    logic [63:0] cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        kind = brw_pkg::KIND_START;
    logic [15:0] directory_half = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        patch_valid;
    logic [31:0] target_offset;
    logic [1:0]  patch_width;
    logic [63:0] addend;
    logic [1:0]  walk_status;

    base_relocation_walker uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .kind           (kind),
        .directory_half (directory_half),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .patch_valid    (patch_valid),
        .target_offset  (target_offset),
        .patch_width    (patch_width),
        .addend         (addend),
        .walk_status    (walk_status)
    );

    // register copies and walk state of the predictor
    logic [31:0]     m_image = '0;
    logic [31:0]     m_dir_bytes = '0;
    logic [63:0]     m_delta = '0;
    brw_pkg::phase_t wphase = brw_pkg::PH_IDLE;
    int unsigned     hdr_step = 0;
    logic [31:0]     page_rva = '0;
    logic [31:0]     blk_bytes = '0;
    logic [30:0]     entries_left = '0;
    logic [31:0]     bytes_done = '0;

    dir_item_t    pending[$];
    walk_result_t walk_results_due[$];
    dir_item_t    next_item;
    walk_result_t want;

    int unsigned  items_made = 0;
    int unsigned  items_in = 0;
    int unsigned  results_seen = 0;
    int unsigned  patches_seen = 0;
    int unsigned  ends_seen = 0;
    int unsigned  settings = 0;
    int unsigned  holds = 0;
    int unsigned  mismatches = 0;
    int unsigned  src_gap = 0;
    int unsigned  src_calm = 0;
    int unsigned  sink_gap = 0;
    int unsigned  sink_calm = 0;
    int unsigned  hold_left = 0;
    int unsigned  next_hold = 300;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic note_mismatch(string what);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t mismatch: %s", $time, what);
    endtask

    function automatic void due_status(logic [1:0] s);
        walk_result_t r;
        r = '0;
        r.st = s;
        walk_results_due.push_back(r);
    endfunction

    function automatic logic [1:0] close_block();
        bytes_done = bytes_done + blk_bytes;
        hdr_step = 0;
        entries_left = '0;
        if (bytes_done >= m_dir_bytes)
        begin
            wphase = brw_pkg::PH_DONE;
            return brw_pkg::ST_FINISHED;
        end
        if (m_dir_bytes - bytes_done < brw_pkg::HEADER_BYTES)
        begin
            wphase = brw_pkg::PH_ERR;
            return brw_pkg::ST_ERROR;
        end
        return brw_pkg::ST_WALKING;
    endfunction

    // One accepted transaction through the walk; queues the result it causes, if any.
    function automatic void advance_walk(logic k, logic [15:0] h);
        logic [3:0]   rtype;
        logic [63:0]  tgt;
        logic [63:0]  span;
        logic [63:0]  add;
        logic [1:0]   pw;
        logic [1:0]   st;
        logic [31:0]  room;
        logic         patch;
        walk_result_t r;
        if (k == brw_pkg::KIND_START)
        begin
            hdr_step = 0;
            page_rva = '0;
            blk_bytes = '0;
            entries_left = '0;
            bytes_done = '0;
            if (m_delta == 0 || m_dir_bytes == 0)
            begin
                wphase = brw_pkg::PH_DONE;
                due_status(brw_pkg::ST_FINISHED);
            end
            else if (m_dir_bytes < brw_pkg::HEADER_BYTES)
            begin
                wphase = brw_pkg::PH_ERR;
                due_status(brw_pkg::ST_ERROR);
            end
            else
                wphase = brw_pkg::PH_WALK;
            return;
        end
        if (wphase != brw_pkg::PH_WALK)
            return;

        if (hdr_step < 4)
        begin
            case (hdr_step)
                0: page_rva = {16'h0, h};
                1: page_rva[31:16] = h;
                2: blk_bytes = {16'h0, h};
                default: blk_bytes[31:16] = h;
            endcase
            hdr_step++;
            if (hdr_step < 4)
                return;
            room = m_dir_bytes - bytes_done;
            if (blk_bytes == 0)
            begin
                wphase = brw_pkg::PH_DONE;
                due_status(brw_pkg::ST_FINISHED);
                return;
            end
            if (blk_bytes < brw_pkg::HEADER_BYTES || blk_bytes > room || blk_bytes[0])
            begin
                wphase = brw_pkg::PH_ERR;
                due_status(brw_pkg::ST_ERROR);
                return;
            end
            entries_left = 31'((blk_bytes - brw_pkg::HEADER_BYTES) >> 1);
            if (entries_left != 0)
                return;
            st = close_block();
            if (st != brw_pkg::ST_WALKING)
                due_status(st);
            return;
        end

        rtype = h[15:12];
        tgt = {32'h0, page_rva} + {52'h0, h[11:0]};
        patch = 1'b1;
        add = m_delta;
        span = 0;
        pw = brw_pkg::PW_16;
        case (rtype)
            brw_pkg::RT_HIGH:
            begin
                span = 2;
                add = m_delta >> 16;
            end
            brw_pkg::RT_LOW:
                span = 2;
            brw_pkg::RT_HIGHLOW:
            begin
                span = 4;
                pw = brw_pkg::PW_32;
            end
            brw_pkg::RT_DIR64:
            begin
                span = 8;
                pw = brw_pkg::PW_64;
            end
            default:
                patch = 1'b0;
        endcase

        if (patch && (tgt >= {32'h0, m_image} || span > {32'h0, m_image} - tgt))
        begin
            wphase = brw_pkg::PH_ERR;
            due_status(brw_pkg::ST_ERROR);
            return;
        end

        entries_left = entries_left - 1'b1;
        st = brw_pkg::ST_WALKING;
        if (entries_left == 0)
            st = close_block();
        if (patch)
        begin
            r.pv = 1'b1;
            r.tgt = tgt[31:0];
            r.pw = pw;
            r.add = add;
            r.st = st;
            walk_results_due.push_back(r);
        end
        else if (st != brw_pkg::ST_WALKING)
            due_status(st);
    endfunction

    function automatic int unsigned draw_gap();
        if ($urandom_range(0, 2) != 0)
            return 0;
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            kind <= brw_pkg::KIND_START;
            directory_half <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                advance_walk(kind, directory_half);
                items_in++;
            end
            if (!(item_valid && item_stall))
            begin
                if (src_gap != 0)
                begin
                    src_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending.size() != 0)
                begin
                    next_item = pending.pop_front();
                    item_valid <= 1'b1;
                    kind <= next_item.k;
                    directory_half <= next_item.h;
                    if (src_calm != 0)
                        src_calm--;
                    else if ($urandom_range(0, 39) == 0)
                        src_calm = $urandom_range(20, 120);
                    else
                        src_gap = draw_gap();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // receiver stall; a long hold every few hundred results lets the block back up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (results_seen >= next_hold)
        begin
            next_hold += 400;
            hold_left = 80;
            holds++;
            result_stall <= 1'b1;
        end
        else if (sink_gap != 0)
        begin
            sink_gap--;
            result_stall <= 1'b1;
        end
        else if (sink_calm != 0)
        begin
            sink_calm--;
            result_stall <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 39) == 0)
                sink_calm = $urandom_range(20, 120);
            else
                sink_gap = draw_gap();
            result_stall <= (sink_gap != 0);
            if (sink_gap != 0)
                sink_gap--;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (walk_results_due.size() == 0)
                note_mismatch($sformatf("unexpected result pv=%0d tgt=%h w=%0d add=%h st=%0d",
                    patch_valid, target_offset, patch_width, addend, walk_status));
            else
            begin
                want = walk_results_due.pop_front();
                if (patch_valid !== want.pv || target_offset !== want.tgt ||
                    patch_width !== want.pw || addend !== want.add || walk_status !== want.st)
                    note_mismatch($sformatf(
                        "got pv=%0d tgt=%h w=%0d add=%h st=%0d, want pv=%0d tgt=%h w=%0d add=%h st=%0d",
                        patch_valid, target_offset, patch_width, addend, walk_status,
                        want.pv, want.tgt, want.pw, want.add, want.st));
                if (want.pv)
                    patches_seen++;
                if (want.st != brw_pkg::ST_WALKING)
                    ends_seen++;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            brw_pkg::CFG_IMAGE_SIZE: m_image = val[31:0];
            brw_pkg::CFG_DIR_BYTES:  m_dir_bytes = val[31:0];
            default:                 m_delta = val;
        endcase
        settings++;
    endtask

    task automatic push_item(logic k, logic [15:0] h);
        dir_item_t it;
        it.k = k;
        it.h = h;
        pending.push_back(it);
        items_made++;
    endtask

    // wait for the sender to drain and all results to land, then a short pause
    task automatic settle();
        int unsigned guard;
        guard = 0;
        while (pending.size() != 0 || item_valid)
            @(posedge clk);
        while (walk_results_due.size() != 0 && guard < 4000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_rva();
        if (m_image > 32'h4000 && $urandom_range(0, 15) != 0)
            return $urandom_range(0, m_image - 32'h2000);
        // near or past the end of the image, wrapping for tiny images
        return m_image - $urandom_range(0, 4200);
    endfunction

    function automatic logic [15:0] pick_entry();
        int unsigned t;
        logic [3:0]  rtype;
        t = $urandom_range(0, 19);
        if (t < 4)
            rtype = brw_pkg::RT_HIGH;
        else if (t < 8)
            rtype = brw_pkg::RT_LOW;
        else if (t < 12)
            rtype = brw_pkg::RT_HIGHLOW;
        else if (t < 16)
            rtype = brw_pkg::RT_DIR64;
        else if (t == 16)
            rtype = brw_pkg::RT_ABSOLUTE;
        else
            rtype = 4'($urandom_range(0, 15));
        return {rtype, 12'($urandom_range(0, 4095))};
    endfunction

    // one directory walk: mostly well formed blocks, now and then a broken one
    task automatic queue_walk();
        logic [31:0] left;
        logic [31:0] blk;
        logic [31:0] rva;
        int unsigned i;
        bit          capped;
        bit          broken;
        push_item(brw_pkg::KIND_START, 16'($urandom_range(0, 16'hFFFF)));
        if (m_delta == 0)
            return;
        capped = (m_dir_bytes > 32'd240);
        left = capped ? $urandom_range(16, 240) : m_dir_bytes;
        broken = 1'b0;
        while (left >= 8)
        begin
            blk = 8 + 2 * $urandom_range(0, 10);
            if (blk > left)
                blk = left;
            else if (left - blk < 8 && $urandom_range(0, 9) != 0)
                blk = left;
            if ($urandom_range(0, 29) == 0)
            begin
                broken = 1'b1;
                case ($urandom_range(0, 3))
                    0: blk = $urandom_range(1, 7);
                    1: blk = blk + 1;
                    2: blk = left + 2 * $urandom_range(1, 8);
                    default: blk = 0;
                endcase
            end
            rva = pick_rva();
            push_item(brw_pkg::KIND_HALF, rva[15:0]);
            push_item(brw_pkg::KIND_HALF, rva[31:16]);
            push_item(brw_pkg::KIND_HALF, blk[15:0]);
            push_item(brw_pkg::KIND_HALF, blk[31:16]);
            if (broken)
                break;
            for (i = 0; i < (blk - 8) / 2; i++)
            begin
                if ($urandom_range(0, 199) == 0)
                    push_item(brw_pkg::KIND_START, 16'($urandom_range(0, 16'hFFFF)));
                push_item(brw_pkg::KIND_HALF, pick_entry());
            end
            left = left - blk;
        end
        if (capped && !broken)
        begin
            // zero-size block ends a walk of an oversized directory
            rva = pick_rva();
            push_item(brw_pkg::KIND_HALF, rva[15:0]);
            push_item(brw_pkg::KIND_HALF, rva[31:16]);
            push_item(brw_pkg::KIND_HALF, 16'h0000);
            push_item(brw_pkg::KIND_HALF, 16'h0000);
        end
    endtask

    initial
    begin
        logic [31:0] img;
        logic [31:0] dir;
        logic [63:0] delta;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // registers at reset: halfword while idle is dropped, zero delta finishes at once
        push_item(brw_pkg::KIND_HALF, 16'hFFFF);
        push_item(brw_pkg::KIND_START, 16'h0000);
        settle();

        write_reg(brw_pkg::CFG_IMAGE_SIZE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(brw_pkg::CFG_BASE_DELTA, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(brw_pkg::CFG_DIR_BYTES, 64'h0);
        push_item(brw_pkg::KIND_START, 16'h0000);
        settle();

        write_reg(brw_pkg::CFG_DIR_BYTES, 64'd6);
        push_item(brw_pkg::KIND_START, 16'hFFFF);
        settle();

        // every entry type at the top of the address space, then a zero-size block,
        // then a target whose sum carries past 32 bits
        write_reg(brw_pkg::CFG_DIR_BYTES, 64'h0000_0000_FFFF_FFFF);
        push_item(brw_pkg::KIND_START, 16'h0000);
        push_item(brw_pkg::KIND_HALF, 16'hF000);
        push_item(brw_pkg::KIND_HALF, 16'hFFFF);
        push_item(brw_pkg::KIND_HALF, 16'h0012);
        push_item(brw_pkg::KIND_HALF, 16'h0000);
        push_item(brw_pkg::KIND_HALF, {brw_pkg::RT_HIGH, 12'h000});
        push_item(brw_pkg::KIND_HALF, {brw_pkg::RT_LOW, 12'hFFD});
        push_item(brw_pkg::KIND_HALF, {brw_pkg::RT_HIGHLOW, 12'h008});
        push_item(brw_pkg::KIND_HALF, {brw_pkg::RT_DIR64, 12'h010});
        push_item(brw_pkg::KIND_HALF, {brw_pkg::RT_ABSOLUTE, 12'h000});
        push_item(brw_pkg::KIND_HALF, 16'h1234);
        push_item(brw_pkg::KIND_HALF, 16'h5678);
        push_item(brw_pkg::KIND_HALF, 16'h0000);
        push_item(brw_pkg::KIND_HALF, 16'h0000);
        push_item(brw_pkg::KIND_START, 16'h0000);
        push_item(brw_pkg::KIND_HALF, 16'hFFFF);
        push_item(brw_pkg::KIND_HALF, 16'hFFFF);
        push_item(brw_pkg::KIND_HALF, 16'h000A);
        push_item(brw_pkg::KIND_HALF, 16'h0000);
        push_item(brw_pkg::KIND_HALF, {brw_pkg::RT_DIR64, 12'hFFF});
        settle();

        while (items_made < 1400)
        begin
            case ($urandom_range(0, 9))
                0: img = 32'h0;
                1: img = 32'hFFFF_FFFF;
                2: img = $urandom_range(1, 64);
                default: img = $urandom_range(32'h3000, 32'h10_0000);
            endcase
            case ($urandom_range(0, 11))
                0: dir = 32'h0;
                1: dir = $urandom_range(1, 7);
                2: dir = 32'hFFFF_FFFF;
                3: dir = $urandom_range(8, 200);
                default: dir = 2 * $urandom_range(4, 100);
            endcase
            case ($urandom_range(0, 9))
                0: delta = 64'h0;
                1: delta = 64'hFFFF_FFFF_FFFF_FFFF;
                default: delta = {32'($urandom), 32'($urandom)};
            endcase
            // upper data bits are don't-care for the 32-bit registers
            write_reg(brw_pkg::CFG_IMAGE_SIZE, {32'($urandom), img});
            write_reg(brw_pkg::CFG_DIR_BYTES, {32'($urandom), dir});
            write_reg(brw_pkg::CFG_BASE_DELTA, delta);
            repeat ($urandom_range(2, 5))
            begin
                queue_walk();
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        push_item(brw_pkg::KIND_HALF, 16'($urandom_range(0, 16'hFFFF)));
            end
            settle();
        end

        settle();
        if (walk_results_due.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", walk_results_due.size()));
        $display("covered %0d transactions over %0d register writes, %0d long output holds",
            items_in, settings, holds);
        $display("checked %0d results: %0d patch commands, %0d walk endings",
            results_seen, patches_seen, ends_seen);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/brw_pkg.sv
hdl/base_relocation_walker.sv
verif/tb.sv
